// ===== rtl/core/metm_pkg.sv =====
// shared types, widths and defaults for the multi-exponential trace mixer
package metm_pkg;

	// default sizes
	localparam int NEURONS_DEF    = 256;
	localparam int COMPONENTS_DEF = 8;

	// field and datapath widths
	localparam int NEURON_W  = 8;
	localparam int SPIKE_W   = 16;
	localparam int OUT_W     = 16;
	localparam int TRACE_W   = 24;
	localparam int COEF_W    = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 4;
	localparam int ACC_W     = 48;
	localparam int MAX_AW    = 16;

	// saturation limits
	localparam logic signed [TRACE_W-1:0] TRACE_MAX = 24'sh7FFFFF;
	localparam logic signed [TRACE_W-1:0] TRACE_MIN = -24'sh800000;
	localparam logic signed [OUT_W-1:0]   OUT_MAX   = 16'sh7FFF;
	localparam logic signed [OUT_W-1:0]   OUT_MIN   = -16'sh8000;

	// word moving down the row of cells
	typedef struct packed {
		logic                       valid;
		logic                       hit;
		logic [NEURON_W-1:0]        neuron;
		logic signed [SPIKE_W-1:0]  spike;
		logic signed [ACC_W-1:0]    acc;
	} item_t;

	// trace clearing sweep control
	typedef struct packed {
		logic              en;
		logic [MAX_AW-1:0] addr;
	} clr_t;

endpackage

// ===== rtl/core/multi_exponential_trace_mixer_top.sv =====
// Multi-exponential trace mixer: per-neuron leaky traces mixed into one current.
// Input channel (in_valid/in_ready) takes a neuron_index and a signed q2.14
// spike_value; each in-range word updates all COMPONENTS traces of that neuron and
// yields one mixed_current word (q2.14) on the output channel (out_valid/out_ready).
// Configuration: cfg_valid/cfg_index/cfg_data write component registers
// (decay in bits 15:0, weight in bits 31:16, both unsigned q0.16); cfg_ready is
// always high, indices at or beyond COMPONENTS are dropped. Write only when idle.
// Throughput: one word per cycle unless stalled; a neuron may repeat back to back.
// Pipeline: an input register and the row of cells, four stages each:
// trace read, update and write-back, weight multiply, accumulate.
// Reset: component and word registers go to zero, and a clearing sweep zeroes
// the trace memories one neuron per cycle; in_ready stays low until it ends.
// Stall: while the output word is held, the next word from the row parks in a skid
// slot; once the slot is full the row freezes and in_ready drops.
module multi_exponential_trace_mixer_top #(
	parameter int NEURONS    = metm_pkg::NEURONS_DEF,
	parameter int COMPONENTS = metm_pkg::COMPONENTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [metm_pkg::NEURON_W-1:0]        neuron_index,
	input  logic signed [metm_pkg::SPIKE_W-1:0]  spike_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [metm_pkg::OUT_W-1:0]    mixed_current,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [metm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [metm_pkg::CFG_W-1:0]           cfg_data
);
	import metm_pkg::*;

	localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

	logic [CFG_W-1:0] comp_q [COMPONENTS];
	logic             clr_busy_q;
	logic [AW-1:0]    clr_cnt_q;
	clr_t             clr;
	logic             adv;
	item_t            in_s0;
	item_t            chain [COMPONENTS+1];

	// component registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < COMPONENTS; c++) begin
				comp_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < COMPONENTS; c++) begin
				if (cfg_valid && (cfg_index == CFG_IDX_W'(c))) begin
					comp_q[c] <= cfg_data;
				end
			end
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(NEURONS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign clr.en   = clr_busy_q;
	assign clr.addr = MAX_AW'(clr_cnt_q);

	// input register
	assign in_ready = adv && !clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s0 <= '0;
		end else if (adv) begin
			in_s0.valid  <= in_valid && in_ready;
			in_s0.hit    <= int'(neuron_index) < NEURONS;
			in_s0.neuron <= neuron_index;
			in_s0.spike  <= spike_value;
			in_s0.acc    <= '0;
		end
	end

	assign chain[0] = in_s0;

	// row of trace cells, one per component
	for (genvar g = 0; g < COMPONENTS; g++) begin : g_cell
		metm_cell #(
			.NEURONS (NEURONS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.clr    (clr),
			.decay  (comp_q[g][COEF_W-1:0]),
			.weight (comp_q[g][CFG_W-1:COEF_W]),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	// rounding and output buffering
	metm_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.din           (chain[COMPONENTS]),
		.adv           (adv),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mixed_current (mixed_current)
	);

endmodule

// ===== rtl/core/metm_cell.sv =====
// one trace cell: per-neuron trace memory, leaky update and weighted accumulate
module metm_cell #(
	parameter int NEURONS = metm_pkg::NEURONS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  metm_pkg::clr_t              clr,
	input  logic [metm_pkg::COEF_W-1:0] decay,
	input  logic [metm_pkg::COEF_W-1:0] weight,
	input  metm_pkg::item_t             din,
	output metm_pkg::item_t             dout
);
	import metm_pkg::*;

	localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

	logic [TRACE_W-1:0]        trace_mem [NEURONS];

	item_t                     item_s1, item_s2, item_s3, item_s4;
	logic signed [TRACE_W-1:0] rdata_s1;
	logic signed [33:0]        pterm_s1;
	logic signed [TRACE_W-1:0] nt_s2;
	logic signed [40:0]        prod_s3;

	logic [AW-1:0]             rd_addr, addr_s1, addr_s2, waddr;
	logic [COEF_W:0]           comp;
	logic signed [33:0]        pterm;
	logic signed [TRACE_W-1:0] t_cur, nt;
	logic signed [40:0]        tdec;
	logic signed [42:0]        mix, rnd, shd;
	logic                      fwd, we;
	logic [TRACE_W-1:0]        wdata;

	assign rd_addr = AW'(din.neuron);
	assign addr_s1 = AW'(item_s1.neuron);
	assign addr_s2 = AW'(item_s2.neuron);

	// spike share of the update, (1 - decay) * spike
	assign comp  = (COEF_W+1)'(18'h10000 - {2'b00, decay});
	assign pterm = din.spike * $signed({1'b0, comp});

	// bypass the word written back one step earlier for the same neuron
	assign fwd   = item_s2.valid && item_s2.hit && item_s1.valid && item_s1.hit
		&& (addr_s2 == addr_s1);
	assign t_cur = fwd ? nt_s2 : rdata_s1;

	// trace update, round half up and saturate to q2.22
	always_comb begin
		tdec = t_cur * $signed({1'b0, decay});
		mix  = 43'(tdec) + (43'(pterm_s1) <<< 8);
		rnd  = mix + $signed(43'(32768));
		shd  = rnd >>> 16;
		if (shd > 43'(TRACE_MAX)) begin
			nt = TRACE_MAX;
		end else if (shd < 43'(TRACE_MIN)) begin
			nt = TRACE_MIN;
		end else begin
			nt = shd[TRACE_W-1:0];
		end
	end

	// write port shared by the clearing sweep and the write-back
	assign we    = clr.en || (adv && item_s1.valid && item_s1.hit);
	assign waddr = clr.en ? AW'(clr.addr) : addr_s1;
	assign wdata = clr.en ? '0 : nt;

	always_ff @(posedge clk) begin
		if (we) begin
			trace_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_s1 <= trace_mem[rd_addr];
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			pterm_s1 <= pterm;
			nt_s2    <= nt;
			prod_s3  <= $signed({1'b0, weight}) * nt_s2;
		end
	end

	// word control and accumulator stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			item_s2 <= '0;
			item_s3 <= '0;
			item_s4 <= '0;
		end else if (adv) begin
			item_s1 <= din;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= '{valid:  item_s3.valid,
			             hit:    item_s3.hit,
			             neuron: item_s3.neuron,
			             spike:  item_s3.spike,
			             acc:    item_s3.acc + ACC_W'(prod_s3)};
		end
	end

	assign dout = item_s4;

`ifndef ASSERT_OFF
	a_clear_idle : assert property (@(posedge clk) disable iff (!arst_n)
		clr.en |-> !item_s1.valid && !din.valid)
		else $error("trace clear overlaps a live word");
	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(nt_s2) && $stable(item_s2))
		else $error("cell stage moved during stall");
	a_wb_range : assert property (@(posedge clk) disable iff (!arst_n)
		(item_s1.valid && item_s1.hit) |-> (int'(addr_s1) < NEURONS))
		else $error("write-back address beyond neuron count");
`endif

endmodule

// ===== rtl/core/metm_outbuf.sv =====
// output rounding, saturation and skid buffer
module metm_outbuf (
	input  logic                              clk,
	input  logic                              arst_n,
	input  metm_pkg::item_t                   din,
	output logic                              adv,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [metm_pkg::OUT_W-1:0] mixed_current
);
	import metm_pkg::*;

	logic                     out_valid_q, skid_valid_q;
	logic signed [OUT_W-1:0]  out_data_q, skid_data_q;
	logic signed [ACC_W-1:0]  rnd, shd;
	logic signed [OUT_W-1:0]  word;
	logic                     push, pop;

	// round q2.38 sum to q2.14 and saturate, zero for an unknown neuron
	always_comb begin
		rnd = din.acc + $signed(ACC_W'(32'h0080_0000));
		shd = rnd >>> 24;
		if (!din.hit) begin
			word = '0;
		end else if (shd > ACC_W'(OUT_MAX)) begin
			word = OUT_MAX;
		end else if (shd < ACC_W'(OUT_MIN)) begin
			word = OUT_MIN;
		end else begin
			word = shd[OUT_W-1:0];
		end
	end

	assign adv  = !skid_valid_q;
	assign push = adv && din.valid;
	assign pop  = out_valid_q && out_ready;

	// output register plus one skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_data_q <= skid_valid_q ? skid_data_q : word;
		end else if (push) begin
			skid_data_q <= word;
		end
	end

	assign out_valid     = out_valid_q;
	assign mixed_current = out_data_q;

`ifndef ASSERT_OFF
	a_skid_behind : assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot full with output empty");
	a_skid_cause : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid slot filled without a stall");
	a_skid_drain : assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_ready) |=> out_valid_q && !skid_valid_q)
		else $error("skid slot did not drain on take");
`endif

endmodule
